// ===== hdl/sbt_pkg.sv =====
// Package: shared constants, codes, state and command/status types of the breakpoint table.
`default_nettype none
package sbt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int ACT_W    = 2;
    localparam int ADDR_W   = 16;
    localparam int POS_W    = 6;
    localparam int USED_W   = 7;

    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_FULL       = 2'd2,
        ST_NO_PROGRAM = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WAIT,
        S_DECIDE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_REM_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic rd_mid;
        logic step;
        logic decide;
        logic ins_step;
        logic put;
        logic rem_step;
        logic dec;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic search_more;
        logic do_insert;
        logic do_remove;
        logic ins_more;
        logic rem_more;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== hdl/sbt_if.sv =====
// Interfaces: request and result channels of the breakpoint table.
`default_nettype none
interface sbt_in_if;
    import sbt_pkg::*;
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output action, output address, input ready);
    modport sink   (input valid, input action, input address, output ready);
endinterface

interface sbt_out_if;
    import sbt_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic              hit;
    logic [POS_W-1:0]  position;
    logic [USED_W-1:0] entries_used;

    modport source (output valid, output status, output hit, output position,
                    output entries_used, input ready);
    modport sink   (input valid, input status, input hit, input position,
                    input entries_used, output ready);
endinterface
`default_nettype wire

// ===== hdl/sbt_ctrl.sv =====
// Controller: sequences search, decision, entry shifting and result hand-off.
`default_nettype none
module sbt_ctrl
    import sbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                n_state = i_sts.search_more ? S_WAIT : S_DECIDE;
            end
            S_WAIT: begin
                n_state = S_SEARCH;
            end
            S_DECIDE: begin
                if (i_sts.do_insert) n_state = S_INS_SHIFT;
                else if (i_sts.do_remove) n_state = S_REM_SHIFT;
                else n_state = S_DONE;
            end
            S_INS_SHIFT: begin
                if (!i_sts.ins_more) n_state = S_INS_PUT;
            end
            S_INS_PUT: begin
                n_state = S_DONE;
            end
            S_REM_SHIFT: begin
                if (!i_sts.rem_more) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SEARCH:    o_cmd.rd_mid   = i_sts.search_more;
            S_WAIT:      o_cmd.step     = 1'b1;
            S_DECIDE:    o_cmd.decide   = 1'b1;
            S_INS_SHIFT: o_cmd.ins_step = i_sts.ins_more;
            S_INS_PUT:   o_cmd.put      = 1'b1;
            S_REM_SHIFT: begin
                o_cmd.rem_step = i_sts.rem_more;
                o_cmd.dec      = !i_sts.rem_more;
            end
            S_DONE:      o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/sbt_dp.sv =====
// Datapath: address memory, search bounds, shift pointer, count and result register.
`default_nettype none
module sbt_dp
    import sbt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [ADDR_W-1:0] i_address,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [1:0]             o_status,
    output logic                   o_hit,
    output logic [POS_W-1:0]       o_position,
    output logic [USED_W-1:0]      o_entries_used
);

    logic [ADDR_W-1:0] r_mem [CAPACITY];
    logic [ADDR_W-1:0] r_rdata;

    logic              r_loaded;
    logic [CW-1:0]     r_count;
    logic [ACT_W-1:0]  r_action;
    logic [ADDR_W-1:0] r_key;
    logic [CW-1:0]     r_lo;
    logic [CW-1:0]     r_hi;
    logic [CW-1:0]     r_mid;
    logic              r_eq;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_wdst;
    logic              r_wpend;
    t_status           r_res_status;
    logic              r_res_hit;
    logic [CW-1:0]     r_res_pos;
    logic              r_out_valid;
    t_status           r_o_status;
    logic              r_o_hit;
    logic [POS_W-1:0]  r_o_pos;
    logic [USED_W-1:0] r_o_used;

    logic [CW-1:0]     w_mid;
    logic [ACT_W-1:0]  w_act;
    logic              w_full;
    logic              w_wr_en;
    logic [CW-1:0]     w_wr_addr;
    logic [ADDR_W-1:0] w_wr_data;
    logic [CW-1:0]     w_rd_addr;
    t_status           n_status;
    logic              n_hit;
    logic [CW-1:0]     n_pos;

    assign w_mid  = r_lo + ((r_hi - r_lo) >> 1);
    assign w_act  = (r_action == ACT_INSERT || r_action == ACT_REMOVE) ? r_action : ACT_LOOKUP;
    assign w_full = (r_count == CW'(CAPACITY));

    assign o_sts.search_more = (r_lo < r_hi);
    assign o_sts.do_insert   = (w_act == ACT_INSERT) && r_loaded && !r_eq && !w_full;
    assign o_sts.do_remove   = (w_act == ACT_REMOVE) && r_loaded && r_eq;
    assign o_sts.ins_more    = (r_ptr > r_lo);
    assign o_sts.rem_more    = (r_ptr < r_count);
    assign o_sts.out_free    = !r_out_valid || i_out_ready;

    // pending shift write drains the word read on the previous cycle
    assign w_wr_en   = r_wpend || i_cmd.put;
    assign w_wr_addr = i_cmd.put ? r_lo : r_wdst;
    assign w_wr_data = i_cmd.put ? r_key : r_rdata;
    assign w_rd_addr = i_cmd.rd_mid   ? w_mid :
                       i_cmd.ins_step ? (r_ptr - CW'(1)) : r_ptr;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr[IW-1:0]] <= w_wr_data;
        r_rdata <= r_mem[w_rd_addr[IW-1:0]];
    end

    always_comb begin
        n_status = ST_OK;
        n_hit    = 1'b0;
        n_pos    = '0;
        if (w_act != ACT_LOOKUP && !r_loaded) begin
            n_status = ST_NO_PROGRAM;
            n_hit    = r_eq;
            n_pos    = r_eq ? r_lo : '0;
        end else begin
            unique case (w_act)
                ACT_INSERT: begin
                    if (r_eq || !w_full) begin
                        n_hit = 1'b1;
                        n_pos = r_lo;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                ACT_REMOVE: begin
                    if (!r_eq) n_status = ST_NOT_FOUND;
                end
                default: begin
                    n_status = r_eq ? ST_OK : ST_NOT_FOUND;
                    n_hit    = r_eq;
                    n_pos    = r_eq ? r_lo : '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= 1'b0;
            r_count     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_loaded <= i_cfg_wr_data;
            if (i_cmd.put) r_count <= r_count + CW'(1);
            else if (i_cmd.dec) r_count <= r_count - CW'(1);
            r_wpend <= i_cmd.ins_step || i_cmd.rem_step;
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_address;
            r_lo     <= '0;
            r_hi     <= r_count;
            r_eq     <= 1'b0;
        end
        if (i_cmd.rd_mid) r_mid <= w_mid;
        if (i_cmd.step) begin
            if (r_rdata < r_key) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
                r_eq <= (r_rdata == r_key);
            end
        end
        if (i_cmd.decide) begin
            r_res_status <= n_status;
            r_res_hit    <= n_hit;
            r_res_pos    <= n_pos;
            r_ptr        <= (w_act == ACT_INSERT) ? r_count : (r_lo + CW'(1));
        end
        if (i_cmd.ins_step) begin
            r_wdst <= r_ptr;
            r_ptr  <= r_ptr - CW'(1);
        end
        if (i_cmd.rem_step) begin
            r_wdst <= r_ptr - CW'(1);
            r_ptr  <= r_ptr + CW'(1);
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_res_status;
            r_o_hit    <= r_res_hit;
            r_o_pos    <= POS_W'(r_res_pos);
            r_o_used   <= USED_W'(r_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_hit          = r_o_hit;
    assign o_position     = r_o_pos;
    assign o_entries_used = r_o_used;

endmodule
`default_nettype wire

// ===== hdl/sorted_breakpoint_table.sv =====
// Top level: sorted breakpoint set with binary search, insert and remove.
// Each halving step of the binary search reads through the registered memory port; an insert
// that lands then shifts the entries above it up and writes the key, a remove that lands shifts
// the entries above it down; up to CAPACITY - 1 entries shift.
// One transaction at a time; the next is taken once the result is held.
// Reset: synchronous; clears the entry count and the program flag, memory is not cleared.
`default_nettype none
module sorted_breakpoint_table
    import sbt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    sbt_in_if.sink    i_in,
    sbt_out_if.source o_out
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_in.ready = w_in_ready;

    sbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sbt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_action       (i_in.action),
        .i_address      (i_in.address),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_status       (o_out.status),
        .o_hit          (o_out.hit),
        .o_position     (o_out.position),
        .o_entries_used (o_out.entries_used)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new transaction taken while one is in flight");

    a_miss_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.hit) |-> (o_out.position == '0))
        else $error("position reported without a hit");

    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.hit) |->
        (o_out.status != ST_NOT_FOUND && o_out.status != ST_FULL))
        else $error("hit reported with a failing status");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == ST_FULL) |-> (o_out.entries_used == USED_W'(CAPACITY)))
        else $error("table full reported below capacity");

endmodule
`default_nettype wire

// ===== sim/sbt_table_checker.sv =====
// Checker for the breakpoint table: watches both channels, predicts each result, compares.
`timescale 1ns / 1ps
module sbt_table_checker
    import sbt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cfg_wr_en,
    input  wire logic i_cfg_wr_data,
    sbt_in_if         req_ch,
    sbt_out_if        rsp_ch,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked
);

    typedef struct packed {
        t_status           status;
        logic              hit;
        logic [POS_W-1:0]  position;
        logic [USED_W-1:0] entries_used;
    } bp_result_t;

    logic [ADDR_W-1:0] bp_addr [CAPACITY_DEF];
    int                bp_count;
    logic              prog_loaded;
    bp_result_t        expected_results [$];

    function automatic bp_result_t breakpoint_step(logic [ACT_W-1:0] act,
                                                   logic [ADDR_W-1:0] addr);
        bp_result_t r;
        int lo;
        int hi;
        int mid;
        logic found;
        lo = 0;
        hi = bp_count;
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (bp_addr[mid] < addr) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        found = (lo < bp_count) && (bp_addr[lo] == addr);
        r.status   = ST_OK;
        r.hit      = found;
        r.position = found ? lo[POS_W-1:0] : '0;
        if (act == ACT_INSERT || act == ACT_REMOVE) begin
            if (!prog_loaded) begin
                r.status = ST_NO_PROGRAM;
            end else if (act == ACT_INSERT) begin
                if (!found) begin
                    if (bp_count >= CAPACITY_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = bp_count; i > lo; i--) bp_addr[i] = bp_addr[i-1];
                        bp_addr[lo] = addr;
                        bp_count++;
                        r.hit      = 1'b1;
                        r.position = lo[POS_W-1:0];
                    end
                end
            end else begin
                if (!found) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    for (int i = lo; i + 1 < bp_count; i++) bp_addr[i] = bp_addr[i+1];
                    bp_count--;
                    r.hit      = 1'b0;
                    r.position = '0;
                end
            end
        end else if (!found) begin
            // lookup, spare code included
            r.status = ST_NOT_FOUND;
        end
        r.entries_used = bp_count[USED_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        bp_result_t want;
        if (!i_rst_n) begin
            bp_count     = 0;
            prog_loaded  = 1'b0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) prog_loaded = i_cfg_wr_data;
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        o_fail_count++;
                    end
                    if (rsp_ch.hit !== want.hit) begin
                        $error("hit: expected %0d, actual %0d", want.hit, rsp_ch.hit);
                        o_fail_count++;
                    end
                    if (rsp_ch.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, rsp_ch.position);
                        o_fail_count++;
                    end
                    if (rsp_ch.entries_used !== want.entries_used) begin
                        $error("entries_used: expected %0d, actual %0d",
                               want.entries_used, rsp_ch.entries_used);
                        o_fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                expected_results.push_back(breakpoint_step(req_ch.action, req_ch.address));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== sim/tb_sorted_breakpoint_table.sv =====
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module tb_sorted_breakpoint_table;
    import sbt_pkg::*;

    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 225;
    localparam int POOL_SIZE      = 96;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_LIMIT    = 20000;

    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_EVEN,
        MIX_DRAIN
    } t_mix;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    sbt_in_if  req_ch ();
    sbt_out_if rsp_ch ();

    int fail_count;
    int pending;
    int checked;
    int sent;
    int idle_pct;
    int stall_pct;
    logic hold_arm;
    logic hold_done;
    int hold_left;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    sorted_breakpoint_table u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (req_ch),
        .o_out         (rsp_ch)
    );

    sbt_table_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .req_ch        (req_ch),
        .rsp_ch        (rsp_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, plus one long hold-off while requests keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_arm && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= LONG_HOLD;
            hold_done    <= 1'b1;
        end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_request(input logic [ACT_W-1:0] act, input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.address <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < DRAIN_LIMIT);
    endtask

    task automatic write_program_flag(input logic value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [ACT_W-1:0] pick_action(t_mix mix);
        int r;
        int ins_w;
        int rem_w;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL:  begin ins_w = 70; rem_w = 8;  end
            MIX_DRAIN: begin ins_w = 10; rem_w = 65; end
            default:   begin ins_w = 35; rem_w = 30; end
        endcase
        if (r < 5) return ACT_SPARE;
        if (r < 5 + ins_w) return ACT_INSERT;
        if (r < 5 + ins_w + rem_w) return ACT_REMOVE;
        return ACT_LOOKUP;
    endfunction

    initial begin
        t_mix mix;
        logic loaded;
        logic [ADDR_W-1:0] addr;
        sent      = 0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_arm  <= 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_LOOKUP;
        req_ch.address <= '0;
        foreach (addr_pool[i]) addr_pool[i] = ADDR_W'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no program after reset: insert and remove refused
        send_request(ACT_LOOKUP, 16'h0000);
        send_request(ACT_INSERT, 16'h1234);
        send_request(ACT_REMOVE, 16'hFFFF);
        send_request(ACT_SPARE,  16'hFFFF);
        drain_results();
        write_program_flag(1'b1);
        send_request(ACT_INSERT, 16'h8000);
        send_request(ACT_INSERT, 16'h0000);
        send_request(ACT_INSERT, 16'hFFFF);
        send_request(ACT_INSERT, 16'h8000);
        send_request(ACT_LOOKUP, 16'h0000);
        send_request(ACT_LOOKUP, 16'hFFFF);
        send_request(ACT_LOOKUP, 16'h8000);
        send_request(ACT_LOOKUP, 16'h5555);
        send_request(ACT_INSERT, 16'h5555);
        send_request(ACT_INSERT, 16'hAAAA);
        send_request(ACT_REMOVE, 16'h8000);
        send_request(ACT_REMOVE, 16'h8000);
        send_request(ACT_SPARE,  16'hAAAA);
        send_request(ACT_SPARE,  16'h1234);
        drain_results();
        write_program_flag(1'b0);
        send_request(ACT_INSERT, 16'h5555);
        send_request(ACT_REMOVE, 16'hAAAA);
        send_request(ACT_LOOKUP, 16'h5555);
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 49; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            if (p == 0 || p == 3 || p == 4) mix = MIX_FILL;
            else if (p == 2 || p == 7)      mix = MIX_DRAIN;
            else                            mix = MIX_EVEN;
            loaded = (p != 3);
            write_program_flag(loaded);
            if (p == 0) hold_arm <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(9) == 0) addr = ADDR_W'($urandom_range(0, 65535));
                else                        addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                send_request(pick_action(mix), addr);
            end
            drain_results();
        end

        repeat (100) @(posedge i_clk);
        $display("Run: %0d requests, %0d results checked over %0d random phases", sent,
                 checked, NUM_PHASES);
        $display("Covered: program flag on and off, table filled and drained, idle/stall mixes");
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
        end
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/sbt_pkg.sv
hdl/sbt_if.sv
hdl/sbt_ctrl.sv
hdl/sbt_dp.sv
hdl/sorted_breakpoint_table.sv
sim/sbt_table_checker.sv
sim/tb_sorted_breakpoint_table.sv
